### hdl/ssp_pkg.sv
// package: shared constants, payload types and codes for the shortest-path engine
`timescale 1ns / 1ps
`default_nettype none
package ssp_pkg;

    localparam int NODES          = 16;
    localparam int EDGES_PER_NODE = 8;
    localparam int WEIGHT_BITS    = 16;

    localparam int DIST_W   = 20;
    localparam int IDX_W    = $clog2(NODES);
    localparam int CNT_W    = $clog2(EDGES_PER_NODE + 1);
    localparam int EADDR_W  = $clog2(NODES * EDGES_PER_NODE);
    localparam int EDGE_W   = IDX_W + WEIGHT_BITS;
    localparam int SUM_W    = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
    localparam logic [1:0] OP_ADD_EDGE   = 2'd1;
    localparam logic [1:0] OP_RUN        = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  first_vertex;
        logic [3:0]  second_vertex;
        logic [15:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        vertex_index;
        logic [DIST_W-1:0] path_distance;
        logic              reachable;
        logic [1:0]        status;
        logic              last;
    } t_out_item;

endpackage
`default_nettype wire

### hdl/ssp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### hdl/single_source_shortest_paths.sv
// top level: graph loading and array-scan dijkstra over a distance ram and an edge ram
//
// Add-vertex and add-edge transactions each return one result.
// In a run from a present source, each selection streams all NODES distances through
// the one read port of the distance ram, each edge walked takes an edge ram read, a
// distance read and, when it improves an unvisited target, a write-back, and each
// visited vertex closes its edge list with one more pass through S_REL_RD. The results
// then leave in ascending vertex order, each present vertex taking a distance read in
// S_OUT_RD and a result in S_OUT_WR, absent vertices being passed over, stalled as
// needed by o_out_valid / i_out_ready. One item is in work at a time.
`timescale 1ns / 1ps
`default_nettype none
module single_source_shortest_paths
    import ssp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SCAN_END = 3'd2;
    localparam logic [2:0] S_REL_RD   = 3'd3;
    localparam logic [2:0] S_REL_T    = 3'd4;
    localparam logic [2:0] S_REL_CMP  = 3'd5;
    localparam logic [2:0] S_OUT_RD   = 3'd6;
    localparam logic [2:0] S_OUT_WR   = 3'd7;

    logic [2:0]         r_state,   n_state;
    logic [NODES-1:0]   r_present, n_present;
    logic [CNT_W-1:0]   r_ecount [NODES];
    logic [CNT_W-1:0]   n_ecount [NODES];
    logic [NODES-1:0]   r_reached, n_reached;
    logic [NODES-1:0]   r_done,    n_done;
    logic [IDX_W-1:0]   r_idx,     n_idx;
    logic [IDX_W-1:0]   r_pidx,    n_pidx;
    logic               r_pval,    n_pval;
    logic               r_found,   n_found;
    logic [IDX_W-1:0]   r_cur,     n_cur;
    logic [DIST_W-1:0]  r_bestd,   n_bestd;
    logic [EADDR_W-1:0] r_eaddr,   n_eaddr;
    logic [CNT_W-1:0]   r_erem,    n_erem;
    logic [IDX_W-1:0]   r_t,       n_t;
    logic [DIST_W-1:0]  r_nd,      n_nd;
    logic               r_o_valid, n_o_valid;
    t_out_item          r_out,     n_out;

    logic               dist_we, dist_re;
    logic [IDX_W-1:0]   dist_waddr, dist_raddr;
    logic [DIST_W-1:0]  dist_wdata, dist_rdata;
    logic               edge_we, edge_re;
    logic [EADDR_W-1:0] edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]  edge_wdata, edge_rdata;

    logic               out_free, in_fire;
    logic [IDX_W-1:0]   a_idx, b_idx;
    logic               a_ok, b_ok;
    logic               e_take;
    logic [IDX_W-1:0]   e_t;
    logic [SUM_W-1:0]   e_sum;
    logic               is_last;

    ssp_ram #(.WIDTH(DIST_W), .DEPTH(NODES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (dist_re),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    ssp_ram #(.WIDTH(EDGE_W), .DEPTH(NODES * EDGES_PER_NODE)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    assign out_free    = !r_o_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    assign a_idx = IDX_W'(i_in_data.first_vertex);
    assign b_idx = IDX_W'(i_in_data.second_vertex);
    assign a_ok  = (32'(i_in_data.first_vertex) < NODES) && r_present[a_idx];
    assign b_ok  = (32'(i_in_data.second_vertex) < NODES) && r_present[b_idx];

    assign e_take = r_pval && r_present[r_pidx] && r_reached[r_pidx] && !r_done[r_pidx]
                    && (!r_found || (dist_rdata < r_bestd));

    assign e_t   = edge_rdata[EDGE_W-1:WEIGHT_BITS];
    assign e_sum = SUM_W'(r_bestd) + SUM_W'(edge_rdata[WEIGHT_BITS-1:0]);

    assign is_last = ((r_present >> r_idx) >> 1) == '0;

    always_comb begin
        n_state   = r_state;
        n_present = r_present;
        n_ecount  = r_ecount;
        n_reached = r_reached;
        n_done    = r_done;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pval    = r_pval;
        n_found   = r_found;
        n_cur     = r_cur;
        n_bestd   = r_bestd;
        n_eaddr   = r_eaddr;
        n_erem    = r_erem;
        n_t       = r_t;
        n_nd      = r_nd;
        n_o_valid = r_o_valid && !i_out_ready;
        n_out     = r_out;

        dist_we    = 1'b0;
        dist_waddr = a_idx;
        dist_wdata = '0;
        dist_re    = 1'b0;
        dist_raddr = r_idx;
        edge_we    = 1'b0;
        edge_waddr = EADDR_W'(32'(a_idx) * EDGES_PER_NODE + 32'(r_ecount[a_idx]));
        edge_wdata = {b_idx, WEIGHT_BITS'(i_in_data.edge_weight)};
        edge_re    = 1'b0;
        edge_raddr = r_eaddr;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_out.vertex_index  = i_in_data.first_vertex;
                    n_out.path_distance = '0;
                    n_out.reachable     = 1'b0;
                    n_out.last          = 1'b1;
                    n_out.status        = ST_OK;
                    unique case (i_in_data.operation)
                        OP_ADD_VERTEX: begin
                            n_o_valid = 1'b1;
                            if (32'(i_in_data.first_vertex) < NODES) begin
                                n_present[a_idx] = 1'b1;
                            end else begin
                                n_out.status = ST_ABSENT;
                            end
                        end
                        OP_ADD_EDGE: begin
                            n_o_valid = 1'b1;
                            if (!a_ok || !b_ok) begin
                                n_out.status = ST_ABSENT;
                            end else if (32'(r_ecount[a_idx]) >= EDGES_PER_NODE) begin
                                n_out.status = ST_FULL;
                            end else begin
                                edge_we         = 1'b1;
                                n_ecount[a_idx] = r_ecount[a_idx] + CNT_W'(1);
                            end
                        end
                        OP_RUN: begin
                            if (!a_ok) begin
                                n_o_valid    = 1'b1;
                                n_out.status = ST_ABSENT;
                            end else begin
                                dist_we   = 1'b1;
                                n_reached = NODES'(1) << a_idx;
                                n_done    = '0;
                                n_idx     = '0;
                                n_pval    = 1'b0;
                                n_found   = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN, S_SCAN_END: begin
                if (e_take) begin
                    n_found = 1'b1;
                    n_cur   = r_pidx;
                    n_bestd = dist_rdata;
                end
                if (r_state == S_SCAN) begin
                    dist_re = 1'b1;
                    n_pval  = 1'b1;
                    n_pidx  = r_idx;
                    if (r_idx == IDX_W'(NODES - 1)) begin
                        n_state = S_SCAN_END;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (n_found) begin
                    n_done  = r_done | (NODES'(1) << n_cur);
                    n_erem  = r_ecount[n_cur];
                    n_eaddr = EADDR_W'(32'(n_cur) * EDGES_PER_NODE);
                    n_state = S_REL_RD;
                end else begin
                    n_idx   = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_REL_RD: begin
                if (r_erem == '0) begin
                    n_idx   = '0;
                    n_pval  = 1'b0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    edge_re = 1'b1;
                    n_eaddr = r_eaddr + EADDR_W'(1);
                    n_erem  = r_erem - CNT_W'(1);
                    n_state = S_REL_T;
                end
            end
            S_REL_T: begin
                n_t        = e_t;
                n_nd       = (e_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(e_sum);
                dist_re    = 1'b1;
                dist_raddr = e_t;
                n_state    = S_REL_CMP;
            end
            S_REL_CMP: begin
                if (!r_done[r_t] && (!r_reached[r_t] || (r_nd < dist_rdata))) begin
                    dist_we        = 1'b1;
                    dist_waddr     = r_t;
                    dist_wdata     = r_nd;
                    n_reached[r_t] = 1'b1;
                end
                n_state = S_REL_RD;
            end
            S_OUT_RD: begin
                if (r_present[r_idx]) begin
                    dist_re = 1'b1;
                    n_state = S_OUT_WR;
                end else if (r_idx == IDX_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_OUT_WR: begin
                if (out_free) begin
                    n_o_valid           = 1'b1;
                    n_out.vertex_index  = 4'(r_idx);
                    n_out.path_distance = r_reached[r_idx] ? dist_rdata : '0;
                    n_out.reachable     = r_reached[r_idx];
                    n_out.status        = ST_OK;
                    n_out.last          = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_ecount[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_o_valid <= n_o_valid;
            r_ecount  <= n_ecount;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reached <= n_reached;
        r_done    <= n_done;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_pval    <= n_pval;
        r_found   <= n_found;
        r_cur     <= n_cur;
        r_bestd   <= n_bestd;
        r_eaddr   <= n_eaddr;
        r_erem    <= n_erem;
        r_t       <= n_t;
        r_nd      <= n_nd;
        r_out     <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_done_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ((r_done & ~r_reached) == '0))
        else $error("visited vertex not marked reached");

    a_erem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL_RD) |-> (32'(r_erem) <= EDGES_PER_NODE))
        else $error("edge walk count beyond list capacity");

    a_select_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_END && n_found) |=> r_done[r_cur])
        else $error("selected vertex not marked visited");

    a_reach_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_out.reachable) |-> (r_out.status == ST_OK))
        else $error("reachable result with error status");
`endif

endmodule
`default_nettype wire
